// ===== design/qsn_pkg.sv =====
`timescale 1ns / 1ps
package qsn_pkg;

  localparam int unsigned COORD_BITS       = 24;
  localparam int unsigned NORMAL_FRAC_BITS = 14;
  localparam int unsigned NORMAL_BITS      = 16;
  localparam int unsigned DIFF_BITS        = COORD_BITS + 1;
  localparam int unsigned SQ_BITS          = 2 * DIFF_BITS;
  localparam int unsigned DIST_BITS        = SQ_BITS + 2;
  localparam int unsigned PROD_BITS        = 2 * DIFF_BITS;
  localparam int unsigned CROSS_BITS       = PROD_BITS + 1;
  localparam int unsigned MANT_BITS        = 31;
  localparam int unsigned MSQ_BITS         = 2 * MANT_BITS;
  localparam int unsigned SUM_BITS         = MSQ_BITS + 2;
  localparam int unsigned SHIFT_BITS       = $clog2(CROSS_BITS - MANT_BITS + 1);
  localparam int unsigned CROSS_LAT        = 7;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t a_x;
    coord_t a_y;
    coord_t a_z;
    coord_t b_x;
    coord_t b_y;
    coord_t b_z;
    coord_t c_x;
    coord_t c_y;
    coord_t c_z;
    coord_t d_x;
    coord_t d_y;
    coord_t d_z;
  } quad_t;

  typedef struct packed {
    logic                          split_ac;
    logic signed [NORMAL_BITS-1:0] first_normal_x;
    logic signed [NORMAL_BITS-1:0] first_normal_y;
    logic signed [NORMAL_BITS-1:0] first_normal_z;
    logic signed [NORMAL_BITS-1:0] second_normal_x;
    logic signed [NORMAL_BITS-1:0] second_normal_y;
    logic signed [NORMAL_BITS-1:0] second_normal_z;
  } result_t;

  typedef struct packed {
    logic signed [DIFF_BITS-1:0] x;
    logic signed [DIFF_BITS-1:0] y;
    logic signed [DIFF_BITS-1:0] z;
  } evec_t;

  typedef struct packed {
    logic valid;
    logic zero;
  } ctrl_t;

endpackage

// ===== design/qsn_front.sv =====
`timescale 1ns / 1ps
module qsn_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  qsn_pkg::quad_t quad_i,
  output logic           valid_o,
  output logic           split_o,
  output qsn_pkg::evec_t tri0_e1_o,
  output qsn_pkg::evec_t tri0_e2_o,
  output qsn_pkg::evec_t tri1_e1_o,
  output qsn_pkg::evec_t tri1_e2_o
);

  localparam int unsigned DW = qsn_pkg::DIFF_BITS;
  localparam int unsigned SW = qsn_pkg::SQ_BITS;
  localparam int unsigned LW = qsn_pkg::DIST_BITS;

  typedef logic signed [DW-1:0] diff_t;

  function automatic diff_t sub(qsn_pkg::coord_t p, qsn_pkg::coord_t q);
    return DW'(p) - DW'(q);
  endfunction

  logic [2:0]           vld_q;
  qsn_pkg::quad_t       s1_quad_q, s2_quad_q;
  diff_t                ac_d [3], ac_q [3], bd_d [3], bd_q [3];
  logic signed [SW-1:0] acsq_d [3], bdsq_d [3];
  logic [SW-1:0]        acsq_q [3], bdsq_q [3];
  logic [LW-1:0]        dac, dbd;
  logic                 split_d, split_q;
  qsn_pkg::evec_t       t0e1_d, t0e2_d, t1e1_d, t1e2_d;
  qsn_pkg::evec_t       t0e1_q, t0e2_q, t1e1_q, t1e2_q;

  assign ac_d[0] = sub(quad_i.c_x, quad_i.a_x);
  assign ac_d[1] = sub(quad_i.c_y, quad_i.a_y);
  assign ac_d[2] = sub(quad_i.c_z, quad_i.a_z);
  assign bd_d[0] = sub(quad_i.d_x, quad_i.b_x);
  assign bd_d[1] = sub(quad_i.d_y, quad_i.b_y);
  assign bd_d[2] = sub(quad_i.d_z, quad_i.b_z);

  for (genvar i = 0; i < 3; i++) begin : g_sq
    assign acsq_d[i] = ac_q[i] * ac_q[i];
    assign bdsq_d[i] = bd_q[i] * bd_q[i];
  end

  always_comb begin
    dac     = LW'(acsq_q[0]) + LW'(acsq_q[1]) + LW'(acsq_q[2]);
    dbd     = LW'(bdsq_q[0]) + LW'(bdsq_q[1]) + LW'(bdsq_q[2]);
    split_d = (dac <= dbd);
    t0e1_d.x = sub(s2_quad_q.b_x, s2_quad_q.a_x);
    t0e1_d.y = sub(s2_quad_q.b_y, s2_quad_q.a_y);
    t0e1_d.z = sub(s2_quad_q.b_z, s2_quad_q.a_z);
    t0e2_d.x = sub(split_d ? s2_quad_q.c_x : s2_quad_q.d_x, s2_quad_q.a_x);
    t0e2_d.y = sub(split_d ? s2_quad_q.c_y : s2_quad_q.d_y, s2_quad_q.a_y);
    t0e2_d.z = sub(split_d ? s2_quad_q.c_z : s2_quad_q.d_z, s2_quad_q.a_z);
    t1e1_d.x = sub(s2_quad_q.c_x, split_d ? s2_quad_q.a_x : s2_quad_q.b_x);
    t1e1_d.y = sub(s2_quad_q.c_y, split_d ? s2_quad_q.a_y : s2_quad_q.b_y);
    t1e1_d.z = sub(s2_quad_q.c_z, split_d ? s2_quad_q.a_z : s2_quad_q.b_z);
    t1e2_d.x = sub(s2_quad_q.d_x, split_d ? s2_quad_q.a_x : s2_quad_q.b_x);
    t1e2_d.y = sub(s2_quad_q.d_y, split_d ? s2_quad_q.a_y : s2_quad_q.b_y);
    t1e2_d.z = sub(s2_quad_q.d_z, split_d ? s2_quad_q.a_z : s2_quad_q.b_z);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    s1_quad_q <= quad_i;
    s2_quad_q <= s1_quad_q;
    for (int i = 0; i < 3; i++) begin
      ac_q[i]   <= ac_d[i];
      bd_q[i]   <= bd_d[i];
      acsq_q[i] <= SW'(acsq_d[i]);
      bdsq_q[i] <= SW'(bdsq_d[i]);
    end
    split_q <= split_d;
    t0e1_q  <= t0e1_d;
    t0e2_q  <= t0e2_d;
    t1e1_q  <= t1e1_d;
    t1e2_q  <= t1e2_d;
  end

  assign valid_o   = vld_q[2];
  assign split_o   = split_q;
  assign tri0_e1_o = t0e1_q;
  assign tri0_e2_o = t0e2_q;
  assign tri1_e1_o = t1e1_q;
  assign tri1_e2_o = t1e2_q;

endmodule

// ===== design/qsn_cross.sv =====
`timescale 1ns / 1ps
module qsn_cross (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  qsn_pkg::evec_t                e1_i,
  input  qsn_pkg::evec_t                e2_i,
  output qsn_pkg::ctrl_t                ctrl_o,
  output logic [2:0]                    neg_o,
  output logic [qsn_pkg::MSQ_BITS-1:0]  msq_o [3],
  output logic [qsn_pkg::SUM_BITS-1:0]  sum_o
);

  localparam int unsigned PW  = qsn_pkg::PROD_BITS;
  localparam int unsigned CW  = qsn_pkg::CROSS_BITS;
  localparam int unsigned MB  = qsn_pkg::MANT_BITS;
  localparam int unsigned QW  = qsn_pkg::MSQ_BITS;
  localparam int unsigned UW  = qsn_pkg::SUM_BITS;
  localparam int unsigned SHW = qsn_pkg::SHIFT_BITS;
  localparam int unsigned NS  = CW - MB;

  logic [6:0]           vld_q;
  logic signed [PW-1:0] prod_d [6], prod_q [6];
  logic signed [CW-1:0] cr_d [3], cr_q [3];
  logic [CW-1:0]        mag_d [3], mag6_q [3], mag7_q [3];
  logic [2:0]           neg_d;
  logic [2:0]           neg_q [5];
  logic                 zero_d;
  logic [4:0]           zero_q;
  logic [CW-1:0]        ors;
  logic [SHW-1:0]       sh_d, sh_q;
  logic [MB-1:0]        mant_q [3];
  logic [QW-1:0]        msq_d [3], msq9_q [3], msq10_q [3];
  logic [UW-1:0]        sum_d, sum_q;

  assign prod_d[0] = e1_i.y * e2_i.z;
  assign prod_d[1] = e1_i.z * e2_i.y;
  assign prod_d[2] = e1_i.z * e2_i.x;
  assign prod_d[3] = e1_i.x * e2_i.z;
  assign prod_d[4] = e1_i.x * e2_i.y;
  assign prod_d[5] = e1_i.y * e2_i.x;

  for (genvar i = 0; i < 3; i++) begin : g_comp
    assign cr_d[i]  = CW'(prod_q[2*i]) - CW'(prod_q[2*i+1]);
    assign neg_d[i] = cr_q[i][CW-1];
    assign mag_d[i] = neg_d[i] ? CW'(-cr_q[i]) : CW'(cr_q[i]);
    assign msq_d[i] = mant_q[i] * mant_q[i];
  end

  assign zero_d = (cr_q[0] == '0) && (cr_q[1] == '0) && (cr_q[2] == '0);
  assign ors    = mag6_q[0] | mag6_q[1] | mag6_q[2];
  assign sum_d  = UW'(msq9_q[0]) + UW'(msq9_q[1]) + UW'(msq9_q[2]);

  // shift that leaves the largest magnitude at MB bits
  always_comb begin
    sh_d = '0;
    for (int i = 0; i < NS; i++) begin
      if (ors[MB+i]) begin
        sh_d = SHW'(i + 1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[5:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 6; i++) begin
      prod_q[i] <= prod_d[i];
    end
    for (int i = 0; i < 3; i++) begin
      cr_q[i]    <= cr_d[i];
      mag6_q[i]  <= mag_d[i];
      mag7_q[i]  <= mag6_q[i];
      mant_q[i]  <= MB'(mag7_q[i] >> sh_q);
      msq9_q[i]  <= msq_d[i];
      msq10_q[i] <= msq9_q[i];
    end
    sh_q     <= sh_d;
    sum_q    <= sum_d;
    neg_q[0] <= neg_d;
    for (int i = 1; i < 5; i++) begin
      neg_q[i] <= neg_q[i-1];
    end
    zero_q <= {zero_q[3:0], zero_d};
  end

  assign ctrl_o.valid = vld_q[6];
  assign ctrl_o.zero  = zero_q[4];
  assign neg_o        = neg_q[4];
  assign msq_o        = msq10_q;
  assign sum_o        = sum_q;

endmodule

// ===== design/qsn_comp.sv =====
`timescale 1ns / 1ps
module qsn_comp #(
  parameter int unsigned NormalFracBits = qsn_pkg::NORMAL_FRAC_BITS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  qsn_pkg::ctrl_t                      ctrl_i,
  input  logic                                neg_i,
  input  logic [qsn_pkg::MSQ_BITS-1:0]        msq_i,
  input  logic [qsn_pkg::SUM_BITS-1:0]        sum_i,
  output logic                                valid_o,
  output logic signed [qsn_pkg::NORMAL_BITS-1:0] normal_o
);

  localparam int unsigned QW  = 2 * NormalFracBits + 3;
  localparam int unsigned RW  = NormalFracBits + 2;
  localparam int unsigned XW  = QW + 1;
  localparam int unsigned UW  = qsn_pkg::SUM_BITS;
  localparam int unsigned NB  = qsn_pkg::NORMAL_BITS;

  logic          dvld_q  [QW];
  logic          dzero_q [QW];
  logic          dneg_q  [QW];
  logic [UW-1:0] drem_q  [QW];
  logic [UW-1:0] dden_q  [QW];
  logic [QW-1:0] dquo_q  [QW];

  logic          svld_q  [RW];
  logic          szero_q [RW];
  logic          sneg_q  [RW];
  logic [QW-1:0] sx_q    [RW];
  logic [XW-1:0] sres_q  [RW];

  logic                 vld_q;
  logic signed [NB-1:0] nrm_d, nrm_q;
  logic [RW:0]          rnd;
  logic [NB-1:0]        mag;

  // restoring divide: msq * 2^(2F+2) / sum, one quotient bit per stage
  for (genvar j = 0; j < QW; j++) begin : g_div
    logic [UW-1:0] rem_in, den_in;
    logic [QW-1:0] quo_in;
    logic          vld_in, zero_in, neg_in, ge;
    logic [UW:0]   shifted, diff;
    if (j == 0) begin : g_first
      assign rem_in  = UW'(msq_i);
      assign den_in  = sum_i;
      assign quo_in  = '0;
      assign vld_in  = ctrl_i.valid;
      assign zero_in = ctrl_i.zero;
      assign neg_in  = neg_i;
      assign shifted = {1'b0, rem_in};
    end else begin : g_next
      assign rem_in  = drem_q[j-1];
      assign den_in  = dden_q[j-1];
      assign quo_in  = dquo_q[j-1];
      assign vld_in  = dvld_q[j-1];
      assign zero_in = dzero_q[j-1];
      assign neg_in  = dneg_q[j-1];
      assign shifted = {rem_in, 1'b0};
    end
    assign ge   = shifted >= {1'b0, den_in};
    assign diff = shifted - {1'b0, den_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dvld_q[j] <= 1'b0;
      end else begin
        dvld_q[j] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      drem_q[j]  <= ge ? diff[UW-1:0] : shifted[UW-1:0];
      dden_q[j]  <= den_in;
      dquo_q[j]  <= {quo_in[QW-2:0], ge};
      dzero_q[j] <= zero_in;
      dneg_q[j]  <= neg_in;
    end
  end

  // digit-by-digit square root of the quotient, one root bit per stage
  for (genvar k = 0; k < RW; k++) begin : g_sqrt
    localparam int unsigned SH = 2 * (RW - 1 - k);
    localparam logic [XW-1:0] BITK = {{(XW-1){1'b0}}, 1'b1} << SH;
    logic [QW-1:0] x_in;
    logic [XW-1:0] res_in, tst;
    logic          vld_in, zero_in, neg_in, ge;
    if (k == 0) begin : g_first
      assign x_in    = dquo_q[QW-1];
      assign res_in  = '0;
      assign vld_in  = dvld_q[QW-1];
      assign zero_in = dzero_q[QW-1];
      assign neg_in  = dneg_q[QW-1];
    end else begin : g_next
      assign x_in    = sx_q[k-1];
      assign res_in  = sres_q[k-1];
      assign vld_in  = svld_q[k-1];
      assign zero_in = szero_q[k-1];
      assign neg_in  = sneg_q[k-1];
    end
    assign tst = res_in + BITK;
    assign ge  = {1'b0, x_in} >= tst;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        svld_q[k] <= 1'b0;
      end else begin
        svld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      sx_q[k]    <= ge ? (x_in - tst[QW-1:0]) : x_in;
      sres_q[k]  <= ge ? ((res_in >> 1) + BITK) : (res_in >> 1);
      szero_q[k] <= zero_in;
      sneg_q[k]  <= neg_in;
    end
  end

  // largest t with (2t-1) <= root
  assign rnd = {1'b0, sres_q[RW-1][RW-1:0]} + 1'b1;
  assign mag = NB'(rnd[RW:1]);

  always_comb begin
    if (szero_q[RW-1]) begin
      nrm_d = '0;
    end else if (sneg_q[RW-1]) begin
      nrm_d = -$signed(mag);
    end else begin
      nrm_d = $signed(mag);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= svld_q[RW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    nrm_q <= nrm_d;
  end

  assign valid_o  = vld_q;
  assign normal_o = nrm_q;

endmodule

// ===== design/quad_split_with_normals.sv =====
`timescale 1ns / 1ps
// Channel  Dir  Ports                  Transfer
// command  in   start, busy, quad_i    start && !busy
// result   out  done_o, result_o       done_o, valid one cycle
//
// Pipeline: 3 front stages, 7 cross-product stages, then one divider stage
// per quotient bit and one square-root stage per root bit, plus the output
// register.
// One quad is accepted every cycle; busy stays low.
// Reset clears only the valid bits; payload stages are not reset.
// No stall path: each result leaves on done_o as it finishes.
module quad_split_with_normals #(
  parameter int unsigned NormalFracBits = qsn_pkg::NORMAL_FRAC_BITS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  qsn_pkg::quad_t   quad_i,
  output logic             done_o,
  output qsn_pkg::result_t result_o
);

  localparam int unsigned CompLat  = 3 * NormalFracBits + 6;
  localparam int unsigned SplitDly = qsn_pkg::CROSS_LAT + CompLat;
  localparam int unsigned QB       = qsn_pkg::MSQ_BITS;
  localparam int unsigned UB       = qsn_pkg::SUM_BITS;
  localparam int unsigned NB       = qsn_pkg::NORMAL_BITS;

  logic           f_valid, f_split;
  qsn_pkg::evec_t t0e1, t0e2, t1e1, t1e2;
  qsn_pkg::ctrl_t c_ctrl [2];
  logic [2:0]     c_neg  [2];
  logic [QB-1:0]  c_msq  [2][3];
  logic [UB-1:0]  c_sum  [2];
  logic           nv     [6];
  logic signed [NB-1:0] nrm [6];
  logic           split_q [SplitDly];

  assign busy = 1'b0;

  qsn_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (start),
    .quad_i    (quad_i),
    .valid_o   (f_valid),
    .split_o   (f_split),
    .tri0_e1_o (t0e1),
    .tri0_e2_o (t0e2),
    .tri1_e1_o (t1e1),
    .tri1_e2_o (t1e2)
  );

  qsn_cross u_cross0 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (f_valid),
    .e1_i    (t0e1),
    .e2_i    (t0e2),
    .ctrl_o  (c_ctrl[0]),
    .neg_o   (c_neg[0]),
    .msq_o   (c_msq[0]),
    .sum_o   (c_sum[0])
  );

  qsn_cross u_cross1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (f_valid),
    .e1_i    (t1e1),
    .e2_i    (t1e2),
    .ctrl_o  (c_ctrl[1]),
    .neg_o   (c_neg[1]),
    .msq_o   (c_msq[1]),
    .sum_o   (c_sum[1])
  );

  for (genvar t = 0; t < 2; t++) begin : g_tri
    for (genvar a = 0; a < 3; a++) begin : g_axis
      qsn_comp #(
        .NormalFracBits (NormalFracBits)
      ) u_comp (
        .clk_i    (clk_i),
        .rst_ni   (rst_ni),
        .ctrl_i   (c_ctrl[t]),
        .neg_i    (c_neg[t][a]),
        .msq_i    (c_msq[t][a]),
        .sum_i    (c_sum[t]),
        .valid_o  (nv[3*t+a]),
        .normal_o (nrm[3*t+a])
      );
    end
  end

  always_ff @(posedge clk_i) begin
    split_q[0] <= f_split;
    for (int i = 1; i < SplitDly; i++) begin
      split_q[i] <= split_q[i-1];
    end
  end

  assign done_o = nv[0] && nv[1] && nv[2] && nv[3] && nv[4] && nv[5];

  assign result_o.split_ac        = split_q[SplitDly-1];
  assign result_o.first_normal_x  = nrm[0];
  assign result_o.first_normal_y  = nrm[1];
  assign result_o.first_normal_z  = nrm[2];
  assign result_o.second_normal_x = nrm[3];
  assign result_o.second_normal_y = nrm[4];
  assign result_o.second_normal_z = nrm[5];

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (nv[0] == nv[1]) && (nv[0] == nv[2]) && (nv[0] == nv[3]) &&
    (nv[0] == nv[4]) && (nv[0] == nv[5]))
    else $error("normal lanes out of step");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    c_ctrl[0].valid == c_ctrl[1].valid)
    else $error("cross-product lanes out of step");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (c_ctrl[0].valid && c_ctrl[0].zero) |-> (c_sum[0] == '0))
    else $error("degenerate first triangle with nonzero sum");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (c_ctrl[1].valid && c_ctrl[1].zero) |-> (c_sum[1] == '0))
    else $error("degenerate second triangle with nonzero sum");

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import qsn_pkg::*;

  localparam int F = NORMAL_FRAC_BITS;
  localparam int CYCLE_LIMIT = 400000;

  logic    clk_i = 1'b0;
  logic    rst_ni = 1'b0;
  logic    start = 1'b0;
  logic    busy;
  quad_t   quad_i = '0;
  logic    done_o;
  result_t result_o;

  quad_t   pending_quads[$];
  result_t expected_results[$];
  int      gap_cnt = 0;
  int      cycle_cnt = 0;
  int      mismatches = 0;
  bit      stretch = 1'b0;

  quad_split_with_normals dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .quad_i(quad_i), .done_o(done_o), .result_o(result_o)
  );

  initial forever #5 clk_i = ~clk_i;

  function automatic logic [47:0] unit_normal(input longint p0[3], input longint p1[3],
                                              input longint p2[3]);
    longint e1[3], e2[3], cr[3];
    logic [63:0] mg[3];
    logic [63:0] ors;
    logic [127:0] m[3], sq, rhs, k, t, o;
    logic [15:0] nrm[3];
    int len, sh;
    for (int i = 0; i < 3; i++) begin
      e1[i] = p1[i] - p0[i];
      e2[i] = p2[i] - p0[i];
    end
    cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
    cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
    cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
    ors = '0;
    for (int i = 0; i < 3; i++) begin
      mg[i] = cr[i] < 0 ? -cr[i] : cr[i];
      ors |= mg[i];
    end
    if (ors == '0) return '0;
    len = 0;
    for (int i = 0; i < 64; i++) if (ors[i]) len = i + 1;
    sh = len > 31 ? len - 31 : 0;
    sq = '0;
    for (int i = 0; i < 3; i++) begin
      m[i] = 128'(mg[i] >> sh);
      sq += m[i] * m[i];
    end
    for (int i = 0; i < 3; i++) begin
      rhs = (m[i] * m[i]) << (2 * F + 2);
      k = '0;
      for (int b = F; b >= 0; b--) begin
        t = k | (128'd1 << b);
        o = 2 * t - 1;
        if (t <= (128'd1 << F) && o * o * sq <= rhs) k = t;
      end
      nrm[i] = cr[i] < 0 ? 16'(-k) : 16'(k);
    end
    return {nrm[0], nrm[1], nrm[2]};
  endfunction

  function automatic result_t predict_split(input quad_t q);
    longint a[3], b[3], c[3], d[3];
    longint dac, dbd;
    result_t r;
    a = '{q.a_x, q.a_y, q.a_z};
    b = '{q.b_x, q.b_y, q.b_z};
    c = '{q.c_x, q.c_y, q.c_z};
    d = '{q.d_x, q.d_y, q.d_z};
    dac = 0;
    dbd = 0;
    for (int i = 0; i < 3; i++) begin
      dac += (c[i] - a[i]) * (c[i] - a[i]);
      dbd += (d[i] - b[i]) * (d[i] - b[i]);
    end
    r.split_ac = dac <= dbd;
    if (r.split_ac) begin
      {r.first_normal_x, r.first_normal_y, r.first_normal_z} = unit_normal(a, b, c);
      {r.second_normal_x, r.second_normal_y, r.second_normal_z} = unit_normal(a, c, d);
    end else begin
      {r.first_normal_x, r.first_normal_y, r.first_normal_z} = unit_normal(a, b, d);
      {r.second_normal_x, r.second_normal_y, r.second_normal_z} = unit_normal(b, c, d);
    end
    return r;
  endfunction

  function automatic coord_t rnd_coord(input int mode);
    case (mode)
      0: return coord_t'($urandom);
      1: return coord_t'($urandom_range(0, 2000)) - 24'sd1000;
      2: return $urandom_range(0, 1) ? 24'sh7fffff - coord_t'($urandom_range(0, 3))
                                     : 24'sh800000 + coord_t'($urandom_range(0, 3));
      default: return coord_t'($urandom_range(0, 16)) - 24'sd8;
    endcase
  endfunction

  function automatic quad_t rnd_quad();
    quad_t q;
    int mode;
    mode = $urandom_range(0, 9);
    if (mode < 4) begin
      q = '{rnd_coord(0), rnd_coord(0), rnd_coord(0), rnd_coord(0), rnd_coord(0),
            rnd_coord(0), rnd_coord(0), rnd_coord(0), rnd_coord(0), rnd_coord(0),
            rnd_coord(0), rnd_coord(0)};
    end else if (mode < 7) begin
      q = '{rnd_coord(1), rnd_coord(1), rnd_coord(1), rnd_coord(1), rnd_coord(1),
            rnd_coord(1), rnd_coord(1), rnd_coord(1), rnd_coord(1), rnd_coord(1),
            rnd_coord(1), rnd_coord(1)};
    end else if (mode == 7) begin
      q = '{rnd_coord(2), rnd_coord(2), rnd_coord(2), rnd_coord(2), rnd_coord(2),
            rnd_coord(2), rnd_coord(2), rnd_coord(2), rnd_coord(2), rnd_coord(2),
            rnd_coord(2), rnd_coord(2)};
    end else begin
      // planar, often symmetric quads: equal diagonals and degenerate triangles
      q = '{rnd_coord(3), rnd_coord(3), 24'sd0, rnd_coord(3), rnd_coord(3), 24'sd0,
            rnd_coord(3), rnd_coord(3), 24'sd0, rnd_coord(3), rnd_coord(3), 24'sd0};
      if (mode == 9) begin
        q.c_x = -q.a_x; q.c_y = -q.a_y; q.d_x = -q.b_x; q.d_y = -q.b_y;
        if ($urandom_range(0, 1)) begin q.b_x = q.a_y; q.b_y = -q.a_x; end
      end
    end
    return q;
  endfunction

  // command driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) expected_results.push_back(predict_split(quad_i));
      if ((start && !busy) || !start) begin
        if (gap_cnt > 0) begin
          gap_cnt <= gap_cnt - 1;
          start <= 1'b0;
        end else if (pending_quads.size() > 0) begin
          quad_i <= pending_quads.pop_front();
          start <= 1'b1;
          if ($urandom_range(0, 49) == 0) stretch = ~stretch;
          gap_cnt <= stretch ? 0 : ($urandom_range(0, 2) == 0 ? $urandom_range(0, 14) : 0);
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transaction: %p", result_o);
      end else begin
        result_t exp_r;
        exp_r = expected_results.pop_front();
        if (result_o !== exp_r) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p actual %p", exp_r, result_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("quad_split_with_normals verification failed");
      $finish;
    end
  end

  initial begin
    quad_t q;
    q = '0;
    pending_quads.push_back(q);
    q = '{default: 24'sh7fffff};
    pending_quads.push_back(q);
    q = '{24'sh800000, 24'sh800000, 24'sh800000, 24'sh7fffff, 24'sh800000, 24'sh7fffff,
          24'sh7fffff, 24'sh7fffff, 24'sh800000, 24'sh800000, 24'sh7fffff, 24'sh7fffff};
    pending_quads.push_back(q);
    q = '{24'sh800000, 24'sh800000, 24'sh0, 24'sh7fffff, 24'sh800000, 24'sh0,
          24'sh7fffff, 24'sh7fffff, 24'sh0, 24'sh800000, 24'sh7fffff, 24'sh0};
    pending_quads.push_back(q);
    // square of side 256, equal diagonals
    q = '{0, 0, 0, 256, 0, 0, 256, 256, 0, 0, 256, 0};
    pending_quads.push_back(q);
    // ac longer
    q = '{0, 0, 0, 256, 0, 0, 1024, 1024, 0, 0, 256, 0};
    pending_quads.push_back(q);
    // collinear points
    q = '{0, 0, 0, 1, 1, 1, 2, 2, 2, 3, 3, 3};
    pending_quads.push_back(q);
    q = '{0, 0, 0, 0, 0, 1, 0, 1, 0, 1, 0, 0};
    pending_quads.push_back(q);
    q = '{-5, 7, 3, 100, -40, 12, 9, 300, -7, -60, -2, 44};
    pending_quads.push_back(q);
    for (int i = 0; i < 1100; i++) pending_quads.push_back(rnd_quad());
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_quads.size() == 0 && !start && expected_results.size() == 0);
    repeat (100) @(posedge clk_i);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("quad_split_with_normals verification clean");
    end else begin
      $display("quad_split_with_normals verification failed");
    end
    $finish;
  end

endmodule
